FILE: rtl/core/refcounted_id_allocator_defines.svh
// ------------------------------------------------------------------------
// refcounted id allocator assertion macros
// shared concurrent check forms, sampled on clk, off while arst_n is low
// ------------------------------------------------------------------------
`ifndef REFCOUNTED_ID_ALLOCATOR_DEFINES_SVH
`define REFCOUNTED_ID_ALLOCATOR_DEFINES_SVH

// consequent checked in the same cycle as the antecedent
`define RCIA_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("refcounted_id_allocator check failed");

// consequent checked from the cycle after the antecedent
`define RCIA_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> cons) \
		else $error("refcounted_id_allocator check failed");

`endif

FILE: rtl/core/rcia_pkg.sv
// ------------------------------------------------------------------------
// rcia_pkg
// types and codes shared by the refcounted id allocator modules
// ------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package rcia_pkg;

	// command codes
	localparam logic [1:0] CMD_CREATE  = 2'd0;
	localparam logic [1:0] CMD_ACQUIRE = 2'd1;
	localparam logic [1:0] CMD_RELEASE = 2'd2;
	localparam logic [1:0] CMD_NONE    = 2'd3;

	// status codes
	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_FULL      = 2'd1;
	localparam logic [1:0] ST_BAD_ID    = 2'd2;
	localparam logic [1:0] ST_SATURATED = 2'd3;

	// request payload
	typedef struct packed {
		logic [1:0] cmd;
		logic [8:0] node_id;
	} req_t;

	// result payload
	typedef struct packed {
		logic [8:0]  result_id;
		logic [1:0]  status;
		logic        freed;
		logic [15:0] count_after;
	} rsp_t;

	// controller to datapath commands
	typedef struct packed {
		logic load;
		logic exec;
	} ctrl_t;

	// controller states
	typedef enum logic [1:0] {
		S_IDLE = 2'b01,
		S_EXEC = 2'b10
	} state_t;

endpackage

`default_nettype wire

FILE: rtl/core/rcia_ctrl.sv
// ------------------------------------------------------------------------
// rcia_ctrl
// sequencer: takes a request, then drives the execute state on the datapath
// ------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rcia_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	output logic                busy,
	output rcia_pkg::ctrl_t     ctrl
);
	import rcia_pkg::*;

	state_t state_q;
	state_t state_d;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (start) state_d = S_EXEC;
			end
			S_EXEC: begin
				state_d = S_IDLE;
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) state_q <= S_IDLE;
		else         state_q <= state_d;
	end

	// commands to the datapath
	assign busy      = (state_q != S_IDLE);
	assign ctrl.load = start && (state_q == S_IDLE);
	assign ctrl.exec = (state_q == S_EXEC);

endmodule

`default_nettype wire

FILE: rtl/core/rcia_dp.sv
// ------------------------------------------------------------------------
// rcia_dp
// slot memory, free list head, fill count and result register
// ------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module rcia_dp #(
	parameter int MAX_NODES  = 256,
	parameter int COUNT_BITS = 16
) (
	input  wire logic            clk,
	input  wire logic            arst_n,
	input  wire rcia_pkg::ctrl_t ctrl,
	input  wire rcia_pkg::req_t  req,
	output logic                 done,
	output rcia_pkg::rsp_t       rsp
);
	import rcia_pkg::*;

	localparam int IDX_W = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
	localparam int ID_W  = $clog2(MAX_NODES + 1);
	localparam int CW    = (ID_W > 9) ? ID_W : 9;
	localparam int WW    = COUNT_BITS + 1;

	// slot word: valid bit over count or link
	logic [WW-1:0]         mem_q [MAX_NODES];
	logic [WW-1:0]         rd_s1;
	logic [1:0]            cmd_s1;
	logic [8:0]            id_s1;

	logic [ID_W-1:0]       free_head_q;
	logic [ID_W-1:0]       free_head_d;
	logic [ID_W-1:0]       used_ids_q;
	logic [ID_W-1:0]       used_ids_d;
	logic                  root_wr_q;

	logic [IDX_W-1:0]      rd_idx;
	logic [IDX_W-1:0]      id_idx;
	logic [ID_W-1:0]       new_slot;
	logic                  wr_en;
	logic [IDX_W-1:0]      wr_idx;
	logic [WW-1:0]         wr_data;
	logic [WW-1:0]         word;
	logic [COUNT_BITS-1:0] cnt;
	logic [COUNT_BITS-1:0] cnt_inc;
	logic [COUNT_BITS-1:0] cnt_dec;
	logic                  link_ok;
	logic                  id_ok;
	logic [CW-1:0]         id_x;
	logic [CW-1:0]         used_x;
	logic [31:0]           cnt_ext;
	logic [31:0]           inc_ext;
	logic [31:0]           dec_ext;
	rsp_t                  rsp_d;

	// read address chosen on the accept cycle
	always_comb begin
		if (req.cmd == CMD_CREATE) rd_idx = IDX_W'(free_head_q - ID_W'(1));
		else                       rd_idx = IDX_W'(req.node_id - 9'd1);
	end

	// slot memory, registered read
	always_ff @(posedge clk) begin
		if (ctrl.exec && wr_en) mem_q[wr_idx] <= wr_data;
		if (ctrl.load) rd_s1 <= mem_q[rd_idx];
	end

	// request capture
	always_ff @(posedge clk) begin
		if (ctrl.load) begin
			cmd_s1 <= req.cmd;
			id_s1  <= req.node_id;
		end
	end

	// root slot reads as live with count one until first written
	assign word    = (id_s1 == 9'd1 && !root_wr_q) ? {1'b1, COUNT_BITS'(1)} : rd_s1;
	assign cnt     = word[COUNT_BITS-1:0];
	assign cnt_inc = cnt + COUNT_BITS'(1);
	assign cnt_dec = cnt - COUNT_BITS'(1);
	assign cnt_ext = 32'(cnt);
	assign inc_ext = 32'(cnt_inc);
	assign dec_ext = 32'(cnt_dec);
	assign id_idx  = IDX_W'(id_s1 - 9'd1);

	// id checks: nonzero, inside the fill count, live
	assign id_x   = CW'(id_s1);
	assign used_x = CW'(used_ids_q);
	assign id_ok  = (id_s1 != 9'd0) && (id_x <= used_x) && word[COUNT_BITS];

	// link popped off the free list must name a slot
	assign link_ok = (33'(rd_s1[COUNT_BITS-1:0]) <= 33'(MAX_NODES));

	// execute: result and write back
	always_comb begin
		wr_en       = 1'b0;
		wr_idx      = id_idx;
		wr_data     = '0;
		free_head_d = free_head_q;
		used_ids_d  = used_ids_q;
		new_slot    = free_head_q;
		rsp_d       = '0;
		case (cmd_s1)
			CMD_CREATE: begin
				if (free_head_q != '0) begin
					new_slot    = free_head_q;
					free_head_d = link_ok ? ID_W'(rd_s1[COUNT_BITS-1:0]) : '0;
				end else begin
					new_slot   = used_ids_q + ID_W'(1);
					used_ids_d = used_ids_q + ID_W'(1);
				end
				if (free_head_q == '0 && used_ids_q >= ID_W'(MAX_NODES)) begin
					used_ids_d   = used_ids_q;
					rsp_d.status = ST_FULL;
				end else begin
					wr_en             = 1'b1;
					wr_idx            = IDX_W'(new_slot - ID_W'(1));
					wr_data           = {1'b1, COUNT_BITS'(1)};
					rsp_d.result_id   = 9'(new_slot);
					rsp_d.count_after = 16'd1;
				end
			end
			CMD_ACQUIRE: begin
				rsp_d.result_id = id_s1;
				if (!id_ok) begin
					rsp_d.status = ST_BAD_ID;
				end else if (cnt == '1) begin
					rsp_d.status      = ST_SATURATED;
					rsp_d.count_after = cnt_ext[15:0];
				end else begin
					wr_en             = 1'b1;
					wr_data           = {1'b1, cnt_inc};
					rsp_d.count_after = inc_ext[15:0];
				end
			end
			CMD_RELEASE: begin
				rsp_d.result_id = id_s1;
				if (!id_ok) begin
					rsp_d.status = ST_BAD_ID;
				end else if (cnt <= COUNT_BITS'(1)) begin
					wr_en       = 1'b1;
					wr_data     = {1'b0, COUNT_BITS'(free_head_q)};
					free_head_d = ID_W'(id_s1);
					rsp_d.freed = 1'b1;
				end else begin
					wr_en             = 1'b1;
					wr_data           = {1'b1, cnt_dec};
					rsp_d.count_after = dec_ext[15:0];
				end
			end
			default: begin
				rsp_d = '0;
			end
		endcase
	end

	// list head, fill count and root flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_head_q <= '0;
			used_ids_q  <= ID_W'(1);
			root_wr_q   <= 1'b0;
			done        <= 1'b0;
		end else begin
			done <= ctrl.exec;
			if (ctrl.exec) begin
				free_head_q <= free_head_d;
				used_ids_q  <= used_ids_d;
				if (wr_en && wr_idx == '0) root_wr_q <= 1'b1;
			end
		end
	end

	// result register
	always_ff @(posedge clk) begin
		if (ctrl.exec) rsp <= rsp_d;
	end

endmodule

`default_nettype wire

FILE: rtl/core/refcounted_id_allocator.sv
// ------------------------------------------------------------------------
// refcounted_id_allocator
// node id allocator with per-slot reference counts and a free list
// ------------------------------------------------------------------------
// A request is taken when start is high and busy is low; busy then stays
// high for one cycle. The request first reads the addressed slot from the
// count memory, then updates it and the list head in the execute cycle.
// The result follows with done high for exactly one cycle, the cycle after
// the execute cycle, and must be captured then since it cannot be held off.
// The memory needs no clearing after reset: ids above the fill count read
// as free and root id 1 reads as live with count one until first written.
`timescale 1ns / 1ps
`default_nettype none

`include "refcounted_id_allocator_defines.svh"

module refcounted_id_allocator #(
	parameter int MAX_NODES  = 256,
	parameter int COUNT_BITS = 16
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           start,
	output logic                busy,
	input  wire rcia_pkg::req_t req,
	output logic                done,
	output rcia_pkg::rsp_t      rsp
);
	import rcia_pkg::*;

	ctrl_t ctrl;

	// sequencer
	rcia_ctrl u_ctrl (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (start),
		.busy   (busy),
		.ctrl   (ctrl)
	);

	// slot memory and list state
	rcia_dp #(
		.MAX_NODES  (MAX_NODES),
		.COUNT_BITS (COUNT_BITS)
	) u_dp (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ctrl),
		.req    (req),
		.done   (done),
		.rsp    (rsp)
	);

	// checks
	`RCIA_ASSERT_NEXT(a_done_after_req, start && !busy, ##1 done)
	`RCIA_ASSERT_NEXT(a_one_exec_cycle, busy, !busy)
	`RCIA_ASSERT_NOW(a_done_not_busy, done, !busy)
	`RCIA_ASSERT_NOW(a_freed_ok, done && rsp.freed, rsp.status == ST_OK && rsp.count_after == 16'd0)

endmodule

`default_nettype wire
